/* hw/rtl/vmntc_pkg.sv */
// ---------------------------------------------------------------------------
// vmntc_pkg
// shared opcodes, stage payload types and float format constants
// ---------------------------------------------------------------------------
package vmntc_pkg;

    typedef enum logic [3:0] {
        OP_I2L = 4'd0,  OP_I2F = 4'd1,  OP_I2D = 4'd2,  OP_L2I = 4'd3,
        OP_L2F = 4'd4,  OP_L2D = 4'd5,  OP_F2I = 4'd6,  OP_F2L = 4'd7,
        OP_F2D = 4'd8,  OP_D2I = 4'd9,  OP_D2L = 4'd10, OP_D2F = 4'd11,
        OP_I2B = 4'd12, OP_I2C = 4'd13, OP_I2S = 4'd14, OP_NONE = 4'd15
    } op_t;

    // result path chosen in the front stage
    typedef enum logic [2:0] {
        PATH_DIRECT = 3'd0,   // value ready in front stage
        PATH_PACK   = 3'd1,   // normalize and round into a float format
        PATH_TOINT  = 3'd2,   // float to integer
        PATH_SPEC   = 3'd3    // special value ready
    } path_t;

    // front stage output: unpacked sign, magnitude and exponent
    typedef struct packed {
        path_t        path;
        logic         is_wide;
        logic         neg;
        logic         dst_dp;      // pack target is double
        logic         dst_long;    // to-int target is long
        logic [63:0]  mag;         // magnitude, or direct value
        logic signed [12:0] exp;   // value = mag * 2^exp
    } front_t;

    // normalize stage output
    typedef struct packed {
        path_t        path;
        logic         is_wide;
        logic         neg;
        logic         dst_dp;
        logic         dst_long;
        logic [63:0]  mag;         // normalized (msb set) or direct value
        logic signed [13:0] bexp;  // biased exponent of msb, or shift count
        logic         zero;
    } norm_t;

    localparam int unsigned SP_MBITS = 23;
    localparam int unsigned DP_MBITS = 52;
    localparam logic [12:0] SP_BIAS  = 13'd127;
    localparam logic [12:0] DP_BIAS  = 13'd1023;

endpackage

/* hw/rtl/vm_numeric_type_converter.sv */
// pipeline: an accepted item is registered in f_reg, then n_reg, then v_reg and w_reg, which drive m_tdata
// throughput: one item per cycle while m_tready is high; a stage advances when the one after it is empty or moving
// reset: aresetn synchronous active low clears the stage valid bits only
// ---------------------------------------------------------------------------
// vm_numeric_type_converter
// three-stage primitive type conversion pipeline: unpack, normalize, round
// ---------------------------------------------------------------------------
module vm_numeric_type_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [3:0] cmd, [67:4] operand, [71:68] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [63:0] result_value, [64] result_is_wide
);
    vmntc_pkg::front_t f_next, f_reg;
    vmntc_pkg::norm_t  n_next, n_reg;
    logic [63:0] v_next, v_reg;
    logic        w_next, w_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        adv3, adv2, adv1;

    // each stage moves when the one after it is empty or moving
    assign adv3 = !v3_reg || m_tready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_tready = adv1;

    vmntc_front u_front (.cmd(s_tdata[3:0]), .operand(s_tdata[67:4]), .f(f_next));
    vmntc_norm  u_norm  (.f(f_reg), .n(n_next));
    vmntc_back  u_back  (.n(n_reg), .value(v_next), .is_wide(w_next));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (adv1) f_reg <= f_next;
        if (adv2) n_reg <= n_next;
        if (adv3) begin
            v_reg <= v_next;
            w_reg <= w_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {7'd0, w_reg, v_reg};

`ifndef SYNTH
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[64] |-> m_tdata[63:32] == 32'd0)
        else $error("narrow result has high word set");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && v2_reg && v3_reg && !m_tready |-> !s_tready)
        else $error("full pipe accepted an item");
`endif
endmodule

/* hw/rtl/vmntc_front.sv */
// ---------------------------------------------------------------------------
// vmntc_front
// decode opcode, unpack operand, handle direct and special results
// ---------------------------------------------------------------------------
module vmntc_front (
    input  logic [3:0]          cmd,
    input  logic [63:0]         operand,
    output vmntc_pkg::front_t   f
);
    logic [31:0] lo;
    logic        fs, ds;
    logic [7:0]  fe;
    logic [10:0] de;
    logic [22:0] ff;
    logic [51:0] df;

    assign lo = operand[31:0];
    assign fs = lo[31];
    assign fe = lo[30:23];
    assign ff = lo[22:0];
    assign ds = operand[63];
    assign de = operand[62:52];
    assign df = operand[51:0];

    always_comb begin
        f = '0;
        f.path = vmntc_pkg::PATH_DIRECT;
        unique case (vmntc_pkg::op_t'(cmd))
            vmntc_pkg::OP_I2L: begin
                f.mag = {{32{lo[31]}}, lo};
                f.is_wide = 1'b1;
            end
            vmntc_pkg::OP_I2F, vmntc_pkg::OP_I2D: begin
                f.path = vmntc_pkg::PATH_PACK;
                f.neg = lo[31];
                f.mag = {32'd0, lo[31] ? (32'd0 - lo) : lo};
                f.dst_dp = (cmd == vmntc_pkg::OP_I2D);
                f.is_wide = f.dst_dp;
            end
            vmntc_pkg::OP_L2I: f.mag = {32'd0, lo};
            vmntc_pkg::OP_L2F, vmntc_pkg::OP_L2D: begin
                f.path = vmntc_pkg::PATH_PACK;
                f.neg = operand[63];
                f.mag = operand[63] ? (64'd0 - operand) : operand;
                f.dst_dp = (cmd == vmntc_pkg::OP_L2D);
                f.is_wide = f.dst_dp;
            end
            vmntc_pkg::OP_F2I, vmntc_pkg::OP_F2L: begin
                f.dst_long = (cmd == vmntc_pkg::OP_F2L);
                f.is_wide = f.dst_long;
                f.neg = fs;
                if (fe == 8'hff && ff != 0) f.path = vmntc_pkg::PATH_SPEC;
                else if (fe == 8'd0) f.path = vmntc_pkg::PATH_SPEC;
                else begin
                    f.path = vmntc_pkg::PATH_TOINT;
                    f.mag = {40'd0, 1'b1, ff};
                    f.exp = 13'(signed'({5'd0, fe})) - 13'sd150;
                end
            end
            vmntc_pkg::OP_D2I, vmntc_pkg::OP_D2L: begin
                f.dst_long = (cmd == vmntc_pkg::OP_D2L);
                f.is_wide = f.dst_long;
                f.neg = ds;
                if (de == 11'h7ff && df != 0) f.path = vmntc_pkg::PATH_SPEC;
                else if (de == 11'd0) f.path = vmntc_pkg::PATH_SPEC;
                else begin
                    f.path = vmntc_pkg::PATH_TOINT;
                    f.mag = {11'd0, 1'b1, df};
                    f.exp = 13'(signed'({2'd0, de})) - 13'sd1075;
                end
            end
            vmntc_pkg::OP_F2D: begin
                f.is_wide = 1'b1;
                f.dst_dp = 1'b1;
                f.neg = fs;
                if (fe == 8'hff) begin
                    f.path = vmntc_pkg::PATH_SPEC;
                    f.mag = {fs, 11'h7ff,
                             (ff != 0) ? {1'b1, ff[21:0], 29'd0} : 52'd0};
                end else begin
                    f.path = vmntc_pkg::PATH_PACK;
                    f.mag = {40'd0, (fe != 0), ff};
                    f.exp = (fe == 0) ? -13'sd149
                          : 13'(signed'({5'd0, fe})) - 13'sd150;
                end
            end
            vmntc_pkg::OP_D2F: begin
                f.neg = ds;
                if (de == 11'h7ff) begin
                    f.path = vmntc_pkg::PATH_SPEC;
                    f.mag = {32'd0, ds, 8'hff,
                             (df != 0) ? {1'b1, df[50:29]} : 23'd0};
                end else begin
                    f.path = vmntc_pkg::PATH_PACK;
                    f.mag = {11'd0, (de != 0), df};
                    f.exp = (de == 0) ? -13'sd1074
                          : 13'(signed'({2'd0, de})) - 13'sd1075;
                end
            end
            vmntc_pkg::OP_I2B: f.mag = {32'd0, {24{lo[7]}}, lo[7:0]};
            vmntc_pkg::OP_I2C: f.mag = {48'd0, lo[15:0]};
            vmntc_pkg::OP_I2S: f.mag = {32'd0, {16{lo[15]}}, lo[15:0]};
            vmntc_pkg::OP_NONE: f.mag = '0;
            default: f.mag = '0;
        endcase
    end
endmodule

/* hw/rtl/vmntc_norm.sv */
// ---------------------------------------------------------------------------
// vmntc_norm
// leading-one normalize for packing, shift setup for float to integer
// ---------------------------------------------------------------------------
module vmntc_norm (
    input  vmntc_pkg::front_t f,
    output vmntc_pkg::norm_t  n
);
    logic [5:0]  lz;
    logic        found;
    logic signed [13:0] bias;

    // leading zero count via priority scan over independent bits
    always_comb begin
        lz = '0;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && f.mag[i]) begin
                lz = 6'(63 - i);
                found = 1'b1;
            end
        end
    end

    assign bias = f.dst_dp ? 14'(vmntc_pkg::DP_BIAS) : 14'(vmntc_pkg::SP_BIAS);

    always_comb begin
        n.path = f.path;
        n.is_wide = f.is_wide;
        n.neg = f.neg;
        n.dst_dp = f.dst_dp;
        n.dst_long = f.dst_long;
        n.zero = !found;
        n.mag = f.mag;
        n.bexp = 14'(f.exp);
        if (f.path == vmntc_pkg::PATH_PACK) begin
            n.mag = f.mag << lz;
            // biased exponent of bit 63 after normalization
            n.bexp = 14'(f.exp) + 14'sd63 - 14'(signed'({8'd0, lz})) + bias;
        end
    end
endmodule

/* hw/rtl/vmntc_back.sv */
// ---------------------------------------------------------------------------
// vmntc_back
// round and pack to float, truncate and saturate to integer, or pass direct and special values
// ---------------------------------------------------------------------------
module vmntc_back (
    input  vmntc_pkg::norm_t n,
    output logic [63:0]      value,
    output logic             is_wide
);
    logic [6:0]  shift;
    logic [63:0] kept, rem, half, body;
    logic        rup;
    logic [10:0] emax;
    logic [5:0]  mb;
    logic [6:0]  extra;
    logic [63:0] sbit;
    logic signed [13:0] unb;
    logic [63:0] ti;
    logic [63:0] maxpos;

    assign mb   = n.dst_dp ? 6'(vmntc_pkg::DP_MBITS) : 6'(vmntc_pkg::SP_MBITS);
    assign emax = n.dst_dp ? 11'h7ff : 11'h0ff;
    assign sbit = n.dst_dp ? {n.neg, 63'd0} : {32'd0, n.neg, 31'd0};

    always_comb begin
        extra = '0;
        if (n.bexp < 14'sd1)
            extra = (n.bexp < -14'sd70) ? 7'd70 : 7'(14'sd1 - n.bexp);
        shift = 7'(7'd63 - {1'b0, mb}) + extra;
        kept = (shift < 7'd64) ? (n.mag >> shift[5:0]) : 64'd0;
        rem  = (shift < 7'd64) ? (n.mag & ((64'd1 << shift[5:0]) - 64'd1)) : n.mag;
        half = (shift <= 7'd64) ? (64'd1 << 6'(shift - 7'd1)) : 64'd0;
        rup  = (shift <= 7'd64) && ((rem > half) || (rem == half && kept[0]));
        if (shift > 7'd64) kept = '0;
        kept = kept + {63'd0, rup};
        if (n.bexp >= 14'sd1)
            body = ({50'd0, 14'(n.bexp - 14'sd1)} << mb) + kept;
        else
            body = kept;
        if ((body >> mb) >= {53'd0, emax} || n.bexp >= $signed({3'd0, emax}))
            body = {53'd0, emax} << mb;
    end

    // float to integer: mag * 2^bexp, bexp is unbiased - mbits
    always_comb begin
        maxpos = n.dst_long ? 64'h7fffffffffffffff : 64'h000000007fffffff;
        unb = n.bexp + (n.mag[52] ? 14'sd52 : 14'sd23);
        if (unb >= (n.dst_long ? 14'sd63 : 14'sd31))
            ti = n.neg ? (maxpos + 64'd1) : maxpos;
        else if (unb < 14'sd0)
            ti = '0;
        else begin
            if (n.bexp >= 14'sd0) ti = n.mag << n.bexp[5:0];
            else                  ti = n.mag >> 6'(-n.bexp);
            if (n.neg) ti = 64'd0 - ti;
        end
        if (!n.dst_long) ti = {32'd0, ti[31:0]};
    end

    always_comb begin
        is_wide = n.is_wide;
        unique case (n.path)
            vmntc_pkg::PATH_PACK:  value = n.zero ? sbit : (sbit | body);
            vmntc_pkg::PATH_TOINT: value = ti;
            default:               value = n.mag;
        endcase
    end
endmodule
